// ===== rtl/ffba_pkg.sv =====
package ffba_pkg;

    // Widths of the transaction fields
    localparam int KIND_W  = 2;
    localparam int FIELD_W = 16;
    localparam int IDX_W   = 10;
    // Byte count of a growing run; stops at the first block that reaches the request
    localparam int RUN_W   = 17;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC   = 2'd0,
        KIND_LOCATE  = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_COMPACT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_ZERO
    } t_state;

endpackage

// ===== rtl/first_fit_block_allocator_core.sv =====
// First-fit block allocator over a map of NUM_BLOCKS owner entries held in
// one synchronous RAM (owner id per block, zero for free).
// Command channel: drive i_kind, i_file_id and i_size_bytes with start; the
// transaction is taken at a clock edge where start is high and busy is low.
// Kinds: allocate (claim lowest free run of ceil(size/BLOCK_BYTES) blocks),
// locate (first run owned by the id), release (free all blocks of the id),
// compact (slide used blocks down in order).
// Result channel: o_first_block, o_last_block and o_ok are valid for one
// cycle while o_valid is high; the receiver cannot stall it, and busy is
// already low in that cycle, so the next command may follow at once.
// The map scan reads one block per cycle through the RAM read port;
// locate and release scan the map (locate stops early at the end of
// the first run), allocate then claims its run in a fill pass, and
// compact then frees the blocks left at the top in a zero pass.
// Allocate with size or id zero, and locate or release of id zero,
// answer at once with no scan. After reset the block sweeps the RAM
// to zero with busy high.
module first_fit_block_allocator_core #(
    parameter int NUM_BLOCKS  = 1024,
    parameter int BLOCK_BYTES = 8,
    parameter int ID_BITS     = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ffba_pkg::KIND_W-1:0]  i_kind,
    input  logic [ffba_pkg::FIELD_W-1:0] i_file_id,
    input  logic [ffba_pkg::FIELD_W-1:0] i_size_bytes,
    output logic                         o_valid,
    output logic [ffba_pkg::IDX_W-1:0]   o_first_block,
    output logic [ffba_pkg::IDX_W-1:0]   o_last_block,
    output logic                         o_ok
);

    localparam int AW = $clog2(NUM_BLOCKS);
    localparam int CW = $clog2(NUM_BLOCKS + 1);
    localparam int FW = ffba_pkg::FIELD_W;
    localparam int XW = ffba_pkg::IDX_W;
    localparam int RW = ffba_pkg::RUN_W;

    localparam logic [CW-1:0] TOP_CNT  = CW'(NUM_BLOCKS);
    localparam logic [CW-1:0] LAST_CNT = CW'(NUM_BLOCKS - 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);
    localparam logic [RW-1:0] BLK_B    = RW'(BLOCK_BYTES);

    // Mask or widen a block index into the result field
    function automatic logic [XW-1:0] to_idx(input logic [AW-1:0] a);
        logic [AW+XW-1:0] w;
        w = {{XW{1'b0}}, a};
        return w[XW-1:0];
    endfunction

    ffba_pkg::t_state r_state, n_state;
    ffba_pkg::t_kind  r_kind, n_kind;
    logic [ID_BITS-1:0] r_id, n_id;
    logic [FW-1:0]      r_size, n_size;
    logic [CW-1:0]      r_rd_ptr, n_rd_ptr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_cur, n_cur;
    logic [RW-1:0]      r_run_bytes, n_run_bytes;
    logic [AW-1:0]      r_run_start, n_run_start;
    logic [AW-1:0]      r_run_end, n_run_end;
    logic               r_found, n_found;
    logic               r_freed, n_freed;
    logic [CW-1:0]      r_wr, n_wr;
    logic [AW-1:0]      r_first, n_first;
    logic [AW-1:0]      r_last, n_last;
    logic               r_valid, n_valid;
    logic [XW-1:0]      r_first_o, n_first_o;
    logic [XW-1:0]      r_last_o, n_last_o;
    logic               r_ok, n_ok;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;
    logic               mem_re;
    logic [ID_BITS-1:0] mem_rdata;

    logic [ID_BITS+FW-1:0] id_ext;
    logic [ID_BITS-1:0]    id_in;
    logic                  is_last;
    logic                  hit;
    logic                  used;
    logic [RW-1:0]         run_next;
    logic [AW-1:0]         start_sel;
    logic [CW-1:0]         wr_next;

    // Mask the id to ID_BITS
    assign id_ext = {{ID_BITS{1'b0}}, i_file_id};
    assign id_in  = id_ext[ID_BITS-1:0];

    assign is_last   = (r_cur == LAST_IDX);
    assign hit       = (mem_rdata == r_id);
    assign used      = (mem_rdata != '0);
    assign run_next  = r_run_bytes + BLK_B;
    assign start_sel = (r_run_bytes == '0) ? r_cur : r_run_start;
    assign wr_next   = used ? (r_wr + CW'(1)) : r_wr;

    ffba_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (ID_BITS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_CLEAR;
            r_pend  <= 1'b0;
            r_wr    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_wr    <= n_wr;
            r_valid <= n_valid;
        end
    end

    // Transaction context and result payload
    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_id        <= n_id;
        r_size      <= n_size;
        r_rd_ptr    <= n_rd_ptr;
        r_cur       <= n_cur;
        r_run_bytes <= n_run_bytes;
        r_run_start <= n_run_start;
        r_run_end   <= n_run_end;
        r_found     <= n_found;
        r_freed     <= n_freed;
        r_first     <= n_first;
        r_last      <= n_last;
        r_first_o   <= n_first_o;
        r_last_o    <= n_last_o;
        r_ok        <= n_ok;
    end

    // Sequencer: scan, fill and sweep passes over the map
    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_id        = r_id;
        n_size      = r_size;
        n_rd_ptr    = r_rd_ptr;
        n_pend      = 1'b0;
        n_cur       = r_cur;
        n_run_bytes = r_run_bytes;
        n_run_start = r_run_start;
        n_run_end   = r_run_end;
        n_found     = r_found;
        n_freed     = r_freed;
        n_wr        = r_wr;
        n_first     = r_first;
        n_last      = r_last;
        n_valid     = 1'b0;
        n_first_o   = r_first_o;
        n_last_o    = r_last_o;
        n_ok        = r_ok;
        mem_we      = 1'b0;
        mem_waddr   = r_wr[AW-1:0];
        mem_wdata   = '0;
        mem_re      = 1'b0;

        case (r_state)
            ffba_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                if (r_wr == LAST_CNT) begin
                    n_state = ffba_pkg::S_IDLE;
                end else begin
                    n_wr = r_wr + CW'(1);
                end
            end

            ffba_pkg::S_IDLE: begin
                if (start) begin
                    n_kind      = ffba_pkg::t_kind'(i_kind);
                    n_id        = id_in;
                    n_size      = i_size_bytes;
                    n_rd_ptr    = '0;
                    n_run_bytes = '0;
                    n_found     = 1'b0;
                    n_freed     = 1'b0;
                    n_wr        = '0;
                    // Reject id zero outside compact, and empty allocations, at once
                    if ((i_kind != ffba_pkg::KIND_COMPACT && id_in == '0) ||
                        (i_kind == ffba_pkg::KIND_ALLOC && i_size_bytes == '0)) begin
                        n_valid   = 1'b1;
                        n_first_o = '0;
                        n_last_o  = '0;
                        n_ok      = 1'b0;
                    end else begin
                        n_state = ffba_pkg::S_SCAN;
                    end
                end
            end

            ffba_pkg::S_SCAN: begin
                // Issue the next read while blocks remain
                if (r_rd_ptr < TOP_CNT) begin
                    mem_re   = 1'b1;
                    n_rd_ptr = r_rd_ptr + CW'(1);
                    n_pend   = 1'b1;
                    n_cur    = r_rd_ptr[AW-1:0];
                end
                if (r_pend) begin
                    case (r_kind)
                        ffba_pkg::KIND_ALLOC: begin
                            if (used) begin
                                n_run_bytes = '0;
                            end else begin
                                n_run_start = start_sel;
                                n_run_bytes = run_next;
                            end
                            if (!used && run_next >= RW'(r_size)) begin
                                n_state   = ffba_pkg::S_FILL;
                                n_pend    = 1'b0;
                                n_run_end = r_cur;
                                n_wr      = CW'(start_sel);
                            end else if (is_last) begin
                                n_state   = ffba_pkg::S_IDLE;
                                n_pend    = 1'b0;
                                n_valid   = 1'b1;
                                n_first_o = '0;
                                n_last_o  = '0;
                                n_ok      = 1'b0;
                            end
                        end

                        ffba_pkg::KIND_LOCATE: begin
                            if (hit) begin
                                n_found = 1'b1;
                                n_last  = r_cur;
                                if (!r_found) begin
                                    n_first = r_cur;
                                end
                            end
                            // Close the run on a mismatch or at the top
                            if ((r_found && !hit) || is_last) begin
                                n_state   = ffba_pkg::S_IDLE;
                                n_pend    = 1'b0;
                                n_valid   = 1'b1;
                                n_ok      = r_found || hit;
                                n_first_o = '0;
                                n_last_o  = '0;
                                if (r_found) begin
                                    n_first_o = to_idx(r_first);
                                    n_last_o  = to_idx(hit ? r_cur : r_last);
                                end else if (hit) begin
                                    n_first_o = to_idx(r_cur);
                                    n_last_o  = to_idx(r_cur);
                                end
                            end
                        end

                        ffba_pkg::KIND_RELEASE: begin
                            if (hit) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_cur;
                                n_freed   = 1'b1;
                            end
                            if (is_last) begin
                                n_state   = ffba_pkg::S_IDLE;
                                n_pend    = 1'b0;
                                n_valid   = 1'b1;
                                n_first_o = '0;
                                n_last_o  = '0;
                                n_ok      = r_freed || hit;
                            end
                        end

                        ffba_pkg::KIND_COMPACT: begin
                            // Write pointer trails the read pointer
                            if (used) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_wr[AW-1:0];
                                mem_wdata = mem_rdata;
                            end
                            n_wr = wr_next;
                            if (is_last) begin
                                n_pend = 1'b0;
                                if (wr_next == TOP_CNT) begin
                                    n_state   = ffba_pkg::S_IDLE;
                                    n_valid   = 1'b1;
                                    n_first_o = '0;
                                    n_last_o  = '0;
                                    n_ok      = 1'b1;
                                end else begin
                                    n_state = ffba_pkg::S_ZERO;
                                end
                            end
                        end

                        default: begin
                            n_state = ffba_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            ffba_pkg::S_FILL: begin
                // Claim the run, one block a cycle
                mem_we    = 1'b1;
                mem_wdata = r_id;
                if (r_wr[AW-1:0] == r_run_end) begin
                    n_state   = ffba_pkg::S_IDLE;
                    n_valid   = 1'b1;
                    n_first_o = to_idx(r_run_start);
                    n_last_o  = to_idx(r_run_end);
                    n_ok      = 1'b1;
                end else begin
                    n_wr = r_wr + CW'(1);
                end
            end

            ffba_pkg::S_ZERO: begin
                // Free the top of the map after compaction
                mem_we = 1'b1;
                if (r_wr == LAST_CNT) begin
                    n_state   = ffba_pkg::S_IDLE;
                    n_valid   = 1'b1;
                    n_first_o = '0;
                    n_last_o  = '0;
                    n_ok      = 1'b1;
                end else begin
                    n_wr = r_wr + CW'(1);
                end
            end

            default: begin
                n_state = ffba_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != ffba_pkg::S_IDLE);
    assign o_valid       = r_valid;
    assign o_first_block = r_first_o;
    assign o_last_block  = r_last_o;
    assign o_ok          = r_ok;

endmodule

// ===== rtl/ffba_mem.sv =====
module ffba_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
